@@ hdl/line_rasterizer_depth_interp_defines.svh @@
// Assertion macros shared by the rasterizer modules.
// Each use expands to one labeled concurrent assertion that is off during reset.
`ifndef LINE_RASTERIZER_DEPTH_INTERP_DEFINES_SVH
`define LINE_RASTERIZER_DEPTH_INTERP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LRDI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LRDI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/lrdi_pkg.sv @@
`default_nettype none

package lrdi_pkg;

	// Field widths of the pixel and depth words
	localparam int COORD_BITS = 12;
	localparam int DEPTH_BITS = 32;

	// Derived widths
	localparam int SPAN_BITS = DEPTH_BITS + 1;
	localparam int CNT_BITS  = COORD_BITS + 1;
	localparam int ERR_BITS  = COORD_BITS + 2;
	localparam int E2_BITS   = COORD_BITS + 3;

	// Divider runs one quotient bit per cycle
	localparam int DIV_STEPS = SPAN_BITS;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	// Command queue between front and back
	localparam int unsigned LRDI_QUEUE_DEPTH = 2;

	// Command codes
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_STEP  = 1'b1;

	typedef struct packed {
		logic                         func;
		logic [COORD_BITS-1:0]        start_x;
		logic [COORD_BITS-1:0]        start_y;
		logic [COORD_BITS-1:0]        end_x;
		logic [COORD_BITS-1:0]        end_y;
		logic signed [DEPTH_BITS-1:0] depth_at_start;
		logic signed [DEPTH_BITS-1:0] depth_at_end;
	} lrdi_in_t;

	typedef struct packed {
		logic                         pixel_valid;
		logic [COORD_BITS-1:0]        pixel_x;
		logic [COORD_BITS-1:0]        pixel_y;
		logic signed [DEPTH_BITS-1:0] pixel_depth;
		logic                         last_pixel;
	} lrdi_out_t;

	// Classified command with line set-up done by the front
	typedef struct packed {
		logic                  is_start;
		logic [COORD_BITS-1:0] x0;
		logic [COORD_BITS-1:0] y0;
		logic [COORD_BITS-1:0] x1;
		logic [COORD_BITS-1:0] y1;
		logic [COORD_BITS-1:0] adx;
		logic [CNT_BITS-1:0]   nady;
		logic                  sx;
		logic                  sy;
		logic [ERR_BITS-1:0]   err;
		logic [CNT_BITS-1:0]   count;
		logic [DEPTH_BITS-1:0] base;
		logic [SPAN_BITS-1:0]  span;
	} lrdi_cmd_t;

	typedef struct packed {
		logic                 start;
		logic [SPAN_BITS-1:0] dividend;
		logic [CNT_BITS-1:0]  divisor;
	} lrdi_div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [SPAN_BITS-1:0] quotient;
		logic [CNT_BITS-1:0]  remainder;
	} lrdi_div_rsp_t;

endpackage

`default_nettype wire

@@ hdl/line_rasterizer_depth_interp.sv @@
// Channel  Handshake                 Word
// -------  ------------------------  -----------------------------------------
// cmd      cmd_valid / cmd_stall     lrdi_in_t: func, endpoints, end depths
// px       px_valid / px_stall       lrdi_out_t: valid, x, y, depth, last flag
// cfg      cfg_we (no handshake)     cfg_wdata: depth_zero_mode
//
// A taken word is registered in the front stage and then written into the command queue;
// px_valid rises once the back unit has moved it into the px register.
// Step words run at one pixel per cycle while px_stall is low. After a start word the back
// unit takes no further word until the bit-serial depth divider has finished.
// Reset clears control state only; there is no clearing pass.
// px_stall holds the px register; the QUEUE_DEPTH-entry queue lets the front keep
// taking words meanwhile.
`default_nettype none

module line_rasterizer_depth_interp #(
	parameter int unsigned QUEUE_DEPTH = lrdi_pkg::LRDI_QUEUE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire lrdi_pkg::lrdi_in_t cmd,
	output logic                    px_valid,
	input  wire logic               px_stall,
	output lrdi_pkg::lrdi_out_t     px,
	input  wire logic               cfg_we,
	input  wire logic               cfg_wdata
);
	import lrdi_pkg::*;

	logic          depth_zero_mode_q;
	logic          push;
	lrdi_cmd_t     push_data;
	logic          full;
	logic          pop;
	logic          pop_valid;
	lrdi_cmd_t     pop_data;
	lrdi_div_req_t div_req;
	lrdi_div_rsp_t div_rsp;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_zero_mode_q <= 1'b0;
		end else if (cfg_we) begin
			depth_zero_mode_q <= cfg_wdata;
		end
	end

	lrdi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	lrdi_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data)
	);

	lrdi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lrdi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.zero_mode (depth_zero_mode_q),
		.q_valid   (pop_valid),
		.q_data    (pop_data),
		.pop       (pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.px_valid  (px_valid),
		.px_stall  (px_stall),
		.px        (px)
	);

endmodule

`default_nettype wire

@@ hdl/lrdi_front.sv @@
`default_nettype none

module lrdi_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire lrdi_pkg::lrdi_in_t  cmd,
	output logic                   push,
	output lrdi_pkg::lrdi_cmd_t    push_data,
	input  wire logic              full
);
	import lrdi_pkg::*;

	logic     valid_s1;
	lrdi_in_t item_s1;

	logic [COORD_BITS-1:0] adx;
	logic [COORD_BITS-1:0] ady;

	// Stall only when a word is held and the queue cannot take it
	assign push      = valid_s1 && !full;
	assign cmd_stall = valid_s1 && full;

	// Hold the accepted word until it moves into the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || push) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_s1 <= cmd;
		end
	end

	// Classify and set up the line
	always_comb begin
		adx = (item_s1.end_x > item_s1.start_x) ? item_s1.end_x - item_s1.start_x
							  : item_s1.start_x - item_s1.end_x;
		ady = (item_s1.end_y > item_s1.start_y) ? item_s1.end_y - item_s1.start_y
							  : item_s1.start_y - item_s1.end_y;
		push_data.is_start = (item_s1.func == FUNC_START);
		push_data.x0       = item_s1.start_x;
		push_data.y0       = item_s1.start_y;
		push_data.x1       = item_s1.end_x;
		push_data.y1       = item_s1.end_y;
		push_data.adx      = adx;
		push_data.nady     = CNT_BITS'(0) - {1'b0, ady};
		push_data.sx       = !(item_s1.start_x < item_s1.end_x);
		push_data.sy       = !(item_s1.start_y < item_s1.end_y);
		push_data.err      = {2'b00, adx} - {2'b00, ady};
		push_data.count    = ((ady > adx) ? {1'b0, ady} : {1'b0, adx}) + 1'b1;
		push_data.base     = item_s1.depth_at_start;
		push_data.span     = {item_s1.depth_at_end[DEPTH_BITS-1], item_s1.depth_at_end}
				   - {item_s1.depth_at_start[DEPTH_BITS-1], item_s1.depth_at_start};
	end

endmodule

`default_nettype wire

@@ hdl/lrdi_queue.sv @@
`default_nettype none
`include "line_rasterizer_depth_interp_defines.svh"

module lrdi_queue #(
	parameter int unsigned DEPTH = lrdi_pkg::LRDI_QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire lrdi_pkg::lrdi_cmd_t  push_data,
	output logic                      full,
	input  wire logic                 pop,
	output logic                      pop_valid,
	output lrdi_pkg::lrdi_cmd_t       pop_data
);
	import lrdi_pkg::*;

	// DEPTH must be at least 2
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	lrdi_cmd_t       entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   fill_q;

	assign full      = (fill_q == CW'(DEPTH));
	assign pop_valid = (fill_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	// Advance pointers with wrap and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	`LRDI_ASSERT_SAME(a_queue_no_overflow, clk, arst_n, push, !full, "push into full queue")
	`LRDI_ASSERT_SAME(a_queue_no_underflow, clk, arst_n, pop, pop_valid, "pop from empty queue")

endmodule

`default_nettype wire

@@ hdl/lrdi_div.sv @@
`default_nettype none
`include "line_rasterizer_depth_interp_defines.svh"

module lrdi_div (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lrdi_pkg::lrdi_div_req_t req,
	output lrdi_pkg::lrdi_div_rsp_t    rsp
);
	import lrdi_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CW-1:0]    step_q;
	logic [SPAN_BITS-1:0] quo_q;
	logic [CNT_BITS-1:0]  rem_q;
	logic [CNT_BITS-1:0]  dvs_q;

	logic [SPAN_BITS-1:0] mag;
	logic [CNT_BITS:0]    trial;
	logic                 fits;

	// Magnitude of the signed span; one restoring step per cycle
	always_comb begin
		mag   = req.dividend[SPAN_BITS-1] ? (~req.dividend + 1'b1) : req.dividend;
		trial = {rem_q, quo_q[SPAN_BITS-1]};
		fits  = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == DIV_CW'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= mag;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SPAN_BITS-2:0], fits};
			rem_q <= fits ? CNT_BITS'(trial - {1'b0, dvs_q}) : CNT_BITS'(trial);
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	`LRDI_ASSERT_SAME(a_div_start_idle, clk, arst_n, req.start, !busy_q, "divider restarted while busy")
	`LRDI_ASSERT_SAME(a_div_rem_below, clk, arst_n, done_q, rem_q < dvs_q, "remainder not below divisor")

endmodule

`default_nettype wire

@@ hdl/lrdi_back.sv @@
`default_nettype none
`include "line_rasterizer_depth_interp_defines.svh"

module lrdi_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  zero_mode,
	input  wire logic                  q_valid,
	input  wire lrdi_pkg::lrdi_cmd_t   q_data,
	output logic                       pop,
	output lrdi_pkg::lrdi_div_req_t    div_req,
	input  wire lrdi_pkg::lrdi_div_rsp_t div_rsp,
	output logic                       px_valid,
	input  wire logic                  px_stall,
	output lrdi_pkg::lrdi_out_t        px
);
	import lrdi_pkg::*;

	// Control state
	logic active_q;
	logic pending_q;
	logic out_valid_q;

	// Line walk state
	logic [COORD_BITS-1:0] cur_x_q;
	logic [COORD_BITS-1:0] cur_y_q;
	logic [COORD_BITS-1:0] goal_x_q;
	logic [COORD_BITS-1:0] goal_y_q;
	logic [COORD_BITS-1:0] adx_q;
	logic [CNT_BITS-1:0]   nady_q;
	logic                  sx_q;
	logic                  sy_q;
	logic [ERR_BITS-1:0]   err_q;
	logic [CNT_BITS-1:0]   count_q;

	// Depth walk state: running depth, remainder and the two increments
	logic                  neg_q;
	logic [DEPTH_BITS-1:0] depth_q;
	logic [CNT_BITS-1:0]   rem_q;
	logic [CNT_BITS-1:0]   rstep_q;
	logic [DEPTH_BITS-1:0] inc0_q;
	logic [DEPTH_BITS-1:0] inc1_q;

	lrdi_out_t out_q;

	logic [E2_BITS-1:0]    e2;
	logic [E2_BITS-1:0]    nady_ext;
	logic [E2_BITS-1:0]    adx_ext;
	logic                  move_x;
	logic                  move_y;
	logic [ERR_BITS-1:0]   err_next;
	logic [COORD_BITS-1:0] x_next;
	logic [COORD_BITS-1:0] y_next;
	logic [CNT_BITS:0]     rsum;
	logic                  carry;
	logic [CNT_BITS-1:0]   rem_next;
	logic [DEPTH_BITS-1:0] depth_next;
	logic [DEPTH_BITS-1:0] qa_x;
	logic                  last;
	lrdi_out_t             word;

	// Take a command when set-up is finished and the output register frees up
	assign pop = q_valid && !pending_q && (!out_valid_q || !px_stall);

	assign div_req.start    = pop && q_data.is_start;
	assign div_req.dividend = q_data.span;
	assign div_req.divisor  = q_data.count;

	// One Bresenham step and one depth step
	always_comb begin
		e2       = {err_q, 1'b0};
		nady_ext = {{2{nady_q[CNT_BITS-1]}}, nady_q};
		adx_ext  = {3'b000, adx_q};
		move_x   = ($signed(e2) >= $signed(nady_ext));
		move_y   = ($signed(e2) <= $signed(adx_ext));
		err_next = err_q + (move_x ? {nady_q[CNT_BITS-1], nady_q} : ERR_BITS'(0))
				 + (move_y ? {2'b00, adx_q} : ERR_BITS'(0));
		x_next   = move_x ? (sx_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1) : cur_x_q;
		y_next   = move_y ? (sy_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1) : cur_y_q;
		rsum     = {1'b0, rem_q} + {1'b0, rstep_q};
		carry    = (rsum >= {1'b0, count_q});
		rem_next = carry ? CNT_BITS'(rsum - {1'b0, count_q}) : CNT_BITS'(rsum);
		depth_next = depth_q + (carry ? inc1_q : inc0_q);
		qa_x     = neg_q ? ~div_rsp.quotient[DEPTH_BITS-1:0]
				 : div_rsp.quotient[DEPTH_BITS-1:0];
	end

	// Build the outgoing word
	always_comb begin
		word = '0;
		last = 1'b0;
		if (q_data.is_start) begin
			last             = (q_data.x0 == q_data.x1) && (q_data.y0 == q_data.y1);
			word.pixel_valid = 1'b1;
			word.pixel_x     = q_data.x0;
			word.pixel_y     = q_data.y0;
			word.pixel_depth = zero_mode ? '0 : q_data.base;
			word.last_pixel  = last;
		end else if (active_q) begin
			last             = (x_next == goal_x_q) && (y_next == goal_y_q);
			word.pixel_valid = 1'b1;
			word.pixel_x     = x_next;
			word.pixel_y     = y_next;
			word.pixel_depth = zero_mode ? '0 : depth_next;
			word.last_pixel  = last;
		end
	end

	// Control: line in progress, depth set-up pending, output occupied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!px_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop && (q_data.is_start || active_q)) begin
				active_q <= !last;
			end
			if (div_req.start) begin
				pending_q <= 1'b1;
			end else if (div_rsp.done) begin
				pending_q <= 1'b0;
			end
		end
	end

	// Line and depth registers
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= word;
		end
		if (pop && q_data.is_start) begin
			cur_x_q  <= q_data.x0;
			cur_y_q  <= q_data.y0;
			goal_x_q <= q_data.x1;
			goal_y_q <= q_data.y1;
			adx_q    <= q_data.adx;
			nady_q   <= q_data.nady;
			sx_q     <= q_data.sx;
			sy_q     <= q_data.sy;
			err_q    <= q_data.err;
			count_q  <= q_data.count;
			neg_q    <= q_data.span[SPAN_BITS-1];
			depth_q  <= q_data.base;
			rem_q    <= '0;
		end else if (pop && active_q) begin
			cur_x_q  <= x_next;
			cur_y_q  <= y_next;
			err_q    <= err_next;
			rem_q    <= rem_next;
			depth_q  <= depth_next;
		end
		// Latch per-pixel quotient and remainder steps once the divide ends
		if (div_rsp.done) begin
			rstep_q <= div_rsp.remainder;
			inc0_q  <= neg_q ? qa_x + 1'b1 : qa_x;
			inc1_q  <= neg_q ? qa_x : qa_x + 1'b1;
		end
	end

	assign px_valid = out_valid_q;
	assign px       = out_q;

	`LRDI_ASSERT_SAME(a_back_done_pending, clk, arst_n, div_rsp.done, pending_q, "divide ended with no set-up pending")
	`LRDI_ASSERT_NEXT(a_back_last_ends, clk, arst_n, pop && word.last_pixel, !active_q, "line still active after last pixel")

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lrdi_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	lrdi_in_t  cmd_word;
	logic      px_valid;
	logic      px_stall;
	lrdi_out_t px_word;
	logic      cfg_we;
	logic      cfg_wdata;

	line_rasterizer_depth_interp dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd_word),
		.px_valid  (px_valid),
		.px_stall  (px_stall),
		.px        (px_word),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Pixel words predicted but not yet seen on the px channel
	lrdi_out_t pixels_due[$];
	int        mismatches = 0;
	int        words_sent = 0;

	// Pacing knobs shared with the sender and the pixel sink
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	int rx_hold = 0;

	// Rasterizer state as the predictor sees it
	logic                         zero_depth_mode;
	logic                         ln_active;
	logic [COORD_BITS-1:0]        pos_x, pos_y, dst_x, dst_y;
	logic [COORD_BITS-1:0]        run_x;
	logic signed [CNT_BITS-1:0]   neg_run_y;
	logic                         dir_x, dir_y;
	logic signed [ERR_BITS-1:0]   bres_err;
	logic [CNT_BITS-1:0]          px_idx, px_cnt;
	logic signed [DEPTH_BITS-1:0] z_base;
	logic signed [SPAN_BITS-1:0]  z_span;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (mismatches < 40)
			$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// Interpolate depth for the current pixel index, exact split division
	function automatic logic signed [DEPTH_BITS-1:0] interp_depth();
		longint          s, b, r;
		longint unsigned mag, n, i, q;
		if (zero_depth_mode)
			return '0;
		s   = z_span;
		b   = z_base;
		mag = (s < 0) ? -s : s;
		n   = (px_cnt == 0) ? 1 : px_cnt;
		i   = px_idx;
		q   = (mag / n) * i + ((mag % n) * i) / n;
		r   = (s < 0) ? b - longint'(q) : b + longint'(q);
		return r[DEPTH_BITS-1:0];
	endfunction

	// Advance the rasterizer state by one command word and return its pixel word
	function automatic lrdi_out_t predict_pixel(input lrdi_in_t w);
		lrdi_out_t             o;
		logic [COORD_BITS-1:0] adx, ady;
		int                    e2, err;
		longint                d;
		o = '0;
		if (w.func == FUNC_START) begin
			adx       = (w.end_x > w.start_x) ? w.end_x - w.start_x : w.start_x - w.end_x;
			ady       = (w.end_y > w.start_y) ? w.end_y - w.start_y : w.start_y - w.end_y;
			pos_x     = w.start_x;
			pos_y     = w.start_y;
			dst_x     = w.end_x;
			dst_y     = w.end_y;
			run_x     = adx;
			neg_run_y = -$signed({1'b0, ady});
			dir_x     = !(w.start_x < w.end_x);
			dir_y     = !(w.start_y < w.end_y);
			err       = int'(adx) - int'(ady);
			bres_err  = err[ERR_BITS-1:0];
			px_idx    = '0;
			px_cnt    = {1'b0, (ady > adx) ? ady : adx} + 1'b1;
			z_base    = $signed(w.depth_at_start);
			d         = longint'($signed(w.depth_at_end)) - longint'($signed(w.depth_at_start));
			z_span    = d[SPAN_BITS-1:0];
			ln_active = 1'b1;
		end else if (!ln_active) begin
			return o;
		end else begin
			// Take one Bresenham step, clamp the index at the last pixel
			err = bres_err;
			e2  = 2 * err;
			if (e2 >= int'(neg_run_y)) begin
				err = err + int'(neg_run_y);
				if (dir_x) pos_x = pos_x - 1'b1;
				else       pos_x = pos_x + 1'b1;
			end
			if (e2 <= int'(run_x)) begin
				err = err + int'(run_x);
				if (dir_y) pos_y = pos_y - 1'b1;
				else       pos_y = pos_y + 1'b1;
			end
			bres_err = err[ERR_BITS-1:0];
			px_idx   = px_idx + 1'b1;
			if (px_idx >= px_cnt)
				px_idx = px_cnt - 1'b1;
		end
		o.pixel_valid = 1'b1;
		o.pixel_x     = pos_x;
		o.pixel_y     = pos_y;
		o.pixel_depth = interp_depth();
		o.last_pixel  = (pos_x == dst_x) && (pos_y == dst_y);
		if (o.last_pixel)
			ln_active = 1'b0;
		return o;
	endfunction

	// Check each delivered pixel word, then record each accepted command word
	always @(posedge clk) begin : word_monitor
		lrdi_out_t want;
		if (arst_n) begin
			if (px_valid && !px_stall) begin
				if (pixels_due.size() == 0) begin
					report_mismatch("pixel word with none pending", 64'(px_word), 64'd0);
				end else begin
					want = pixels_due.pop_front();
					if (px_word.pixel_valid !== want.pixel_valid)
						report_mismatch("pixel_valid", 64'(px_word.pixel_valid),
							64'(want.pixel_valid));
					if (px_word.pixel_x !== want.pixel_x)
						report_mismatch("pixel_x", 64'(px_word.pixel_x), 64'(want.pixel_x));
					if (px_word.pixel_y !== want.pixel_y)
						report_mismatch("pixel_y", 64'(px_word.pixel_y), 64'(want.pixel_y));
					if (px_word.pixel_depth !== want.pixel_depth)
						report_mismatch("pixel_depth", 64'(px_word.pixel_depth),
							64'(want.pixel_depth));
					if (px_word.last_pixel !== want.last_pixel)
						report_mismatch("last_pixel", 64'(px_word.last_pixel),
							64'(want.last_pixel));
				end
			end
			if (cmd_valid && !cmd_stall)
				pixels_due.push_back(predict_pixel(cmd_word));
		end
	end

	// Pixel sink: stall a random number of cycles before each word, or a long hold on request
	initial begin : pixel_sink
		int gap;
		px_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold != 0) begin
				gap     = rx_hold;
				rx_hold = 0;
			end else begin
				gap = rx_calm ? 0 : $urandom_range(0, 17);
			end
			if (gap != 0) begin
				px_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			px_stall <= 1'b0;
			do @(posedge clk); while (!px_valid);
		end
	end

	// Offer one command word after a random gap and hold it until taken
	task automatic send_word(input lrdi_in_t w);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 17);
		@(negedge clk);
		if (gap != 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word  <= w;
		do @(posedge clk); while (cmd_stall);
		words_sent++;
	endtask

	function automatic lrdi_in_t start_word(input int x0, input int y0, input int x1,
			input int y1, input logic [31:0] d0, input logic [31:0] d1);
		lrdi_in_t w;
		w.func           = FUNC_START;
		w.start_x        = x0[COORD_BITS-1:0];
		w.start_y        = y0[COORD_BITS-1:0];
		w.end_x          = x1[COORD_BITS-1:0];
		w.end_y          = y1[COORD_BITS-1:0];
		w.depth_at_start = d0;
		w.depth_at_end   = d1;
		return w;
	endfunction

	// Step word with junk in the fields that a step ignores
	function automatic lrdi_in_t step_word();
		lrdi_in_t    w;
		logic [31:0] r0, r1;
		r0               = $urandom;
		r1               = $urandom;
		w.func           = FUNC_STEP;
		w.start_x        = r0[COORD_BITS-1:0];
		w.start_y        = r0[2*COORD_BITS-1:COORD_BITS];
		w.end_x          = r1[COORD_BITS-1:0];
		w.end_y          = r1[2*COORD_BITS-1:COORD_BITS];
		w.depth_at_start = $urandom;
		w.depth_at_end   = $urandom;
		return w;
	endfunction

	function automatic int line_len(input int x0, input int y0, input int x1, input int y1);
		int ax, ay;
		ax = (x1 > x0) ? x1 - x0 : x0 - x1;
		ay = (y1 > y0) ? y1 - y0 : y0 - y1;
		return (ax > ay) ? ax : ay;
	endfunction

	function automatic int near(input int c, input int reach);
		int v;
		v = c + $urandom_range(0, 2 * reach) - reach;
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return v;
	endfunction

	function automatic logic [31:0] pick_depth();
		case ($urandom_range(0, 5))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return 32'h0;
			3:       return 32'($urandom_range(0, 2000) - 1000);
			default: return $urandom;
		endcase
	endfunction

	task automatic run_line(input int x0, input int y0, input int x1, input int y1,
			input logic [31:0] d0, input logic [31:0] d1, input int steps);
		send_word(start_word(x0, y0, x1, y1, d0, d1));
		repeat (steps) send_word(step_word());
	endtask

	// Drop valid and wait until every predicted pixel word has come back
	task automatic drain_pixels();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
	endtask

	task automatic set_depth_zero(input logic v);
		drain_pixels();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		zero_depth_mode = v;
	endtask

	task automatic test_idle_step();
		repeat (2) send_word(step_word());
	endtask

	task automatic test_degenerate();
		run_line(0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 1);
		run_line(4095, 4095, 4095, 4095, 32'h8000_0000, 32'h7fff_ffff, 0);
	endtask

	// Abandon a line mid-way, then finish the next one and step past its end
	task automatic test_restart();
		run_line(4095, 4095, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 2);
		run_line(4095, 0, 4093, 3, 32'h7fff_ffff, 32'h8000_0000, 3);
		send_word(step_word());
	endtask

	task automatic test_line_shapes();
		run_line(0, 4095, 3, 4094, 32'h0001_0000, 32'hfffe_0000, 3);
		run_line(10, 10, 12, 16, 32'h0000_0000, 32'h0006_8000, 6);
	endtask

	task automatic test_random_lines(input int n_words);
		int stop, x0, y0, x1, y1, len, kind, reach;
		stop = words_sent + n_words;
		while (words_sent < stop) begin
			tx_calm = ($urandom_range(0, 5) == 0);
			rx_calm = ($urandom_range(0, 5) == 0);
			reach   = ($urandom_range(0, 19) == 0) ? 120 : 12;
			x0      = $urandom_range(0, 4095);
			y0      = $urandom_range(0, 4095);
			x1      = near(x0, reach);
			y1      = near(y0, reach);
			len     = line_len(x0, y0, x1, y1);
			kind    = $urandom_range(0, 99);
			if (kind < 72)
				run_line(x0, y0, x1, y1, pick_depth(), pick_depth(), len);
			else if (kind < 86)
				run_line(x0, y0, x1, y1, pick_depth(), pick_depth(), $urandom_range(0, len));
			else if (kind < 94)
				repeat ($urandom_range(1, 3)) send_word(step_word());
			else
				run_line($urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom, $urandom, $urandom_range(0, 4));
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// Hold the sink for a long stretch while words keep coming, so the queue backs up
	task automatic test_queue_fill();
		tx_calm = 1'b1;
		rx_hold = 400;
		run_line(200, 300, 290, 340, pick_depth(), pick_depth(), 90);
		run_line(4000, 10, 3950, 70, pick_depth(), pick_depth(), 60);
		tx_calm = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd_word  = '0;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		zero_depth_mode = 1'b0;
		ln_active = 1'b0;
		pos_x = '0; pos_y = '0; dst_x = '0; dst_y = '0;
		run_x = '0; neg_run_y = '0; dir_x = 1'b0; dir_y = 1'b0;
		bres_err = '0; px_idx = '0; px_cnt = '0; z_base = '0; z_span = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		set_depth_zero(1'b0);
		test_idle_step();
		test_degenerate();
		test_restart();
		test_line_shapes();
		test_random_lines(700);
		set_depth_zero(1'b1);
		test_random_lines(350);
		set_depth_zero(1'b0);
		test_queue_fill();
		test_random_lines(500);

		drain_pixels();
		repeat (DEPTH_BITS + 8) @(posedge clk);
		if (pixels_due.size() != 0)
			report_mismatch("words never delivered", 64'(pixels_due.size()), 64'd0);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Stop a hung run
	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
